FILE: rtl/tds_pkg.sv
// Shared types and helpers for the tridiagonal sweep solver.
// Word structs for both channels, register codes and 33-bit saturation.
`timescale 1ns / 1ps
package tds_pkg;

    typedef struct packed {
        logic signed [31:0] sub_coef;
        logic signed [31:0] diag_coef;
        logic signed [31:0] super_coef;
        logic signed [31:0] rhs_value;
    } row_word_t;

    typedef struct packed {
        logic signed [31:0] x_value;
        logic        [3:0]  x_index;
        logic               last_flag;
        logic               singular;
    } sol_word_t;

    localparam logic [1:0]         ADDR_ROWS_IN_USE = 2'd0;
    localparam logic [4:0]         ROWS_RESET = 5'd4;
    localparam logic [4:0]         ROWS_MIN   = 5'd2;
    localparam logic signed [31:0] FIX_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] FIX_MIN    = 32'sh8000_0000;
    localparam logic signed [32:0] WIDE_MAX   = 33'sh0_7FFF_FFFF;
    localparam logic signed [32:0] WIDE_MIN   = 33'sh1_8000_0000;

    function automatic logic ovf33(input logic signed [32:0] v);
        ovf33 = (v > WIDE_MAX) || (v < WIDE_MIN);
    endfunction

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v > WIDE_MAX)
        begin
            sat33 = FIX_MAX;
        end
        else if (v < WIDE_MIN)
        begin
            sat33 = FIX_MIN;
        end
        else
        begin
            sat33 = v[31:0];
        end
    endfunction

endpackage

FILE: rtl/tds_store.sv
// P and Q sweep stores: one write and one read address per cycle, registered read data.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
module tds_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          clk,
    input  logic          wr_p,
    input  logic          wr_q,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_p_data,
    input  logic [31:0]   wr_q_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_p_data,
    output logic [31:0]   rd_q_data
);

    logic [31:0] p_mem [DEPTH];
    logic [31:0] q_mem [DEPTH];
    logic [31:0] rd_p_reg;
    logic [31:0] rd_q_reg;

    always_ff @(posedge clk)
    begin
        if (wr_p)
        begin
            p_mem[wr_addr] <= wr_p_data;
        end
        if (wr_q)
        begin
            q_mem[wr_addr] <= wr_q_data;
        end
        if (rd_en)
        begin
            rd_p_reg <= p_mem[rd_addr];
            rd_q_reg <= q_mem[rd_addr];
        end
    end

    assign rd_p_data = rd_p_reg;
    assign rd_q_data = rd_q_reg;

endmodule

FILE: rtl/tds_mul.sv
// Fixed-point multiplier: registered 32x32 product, then round half up and saturate.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
module tds_mul #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               start,
    input  logic signed [31:0] x,
    input  logic signed [31:0] y,
    output logic signed [31:0] res,
    output logic               ovf
);

    localparam logic signed [63:0] RND = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [63:0] LIM_HI = 64'sd2147483647;
    localparam logic signed [63:0] LIM_LO = -64'sd2147483648;

    logic signed [63:0] prod_reg;
    logic signed [63:0] rounded;
    logic signed [63:0] shifted;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= 64'(x) * 64'(y);
        end
    end

    always_comb
    begin
        rounded = prod_reg + RND;
        shifted = rounded >>> FRAC_BITS;
        ovf     = (shifted > LIM_HI) || (shifted < LIM_LO);
        if (shifted > LIM_HI)
        begin
            res = 32'sh7FFF_FFFF;
        end
        else if (shifted < LIM_LO)
        begin
            res = 32'sh8000_0000;
        end
        else
        begin
            res = shifted[31:0];
        end
    end

endmodule

FILE: rtl/tds_div.sv
// Serial restoring divider: (num << FRAC_BITS) / den, truncated toward zero, saturated.
// Uses tds_pkg for the saturation limits; one quotient bit per cycle.
`timescale 1ns / 1ps
module tds_div
    import tds_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [32:0] num,
    input  logic signed [31:0] den,
    output logic               done,
    output logic signed [31:0] quot,
    output logic               err
);

    localparam int QW = 32 + FRAC_BITS;
    localparam int CNTW = $clog2(QW + 1);
    localparam logic [QW-1:0] POS_LIM = QW'(64'h7FFF_FFFF);
    localparam logic [QW-1:0] NEG_LIM = QW'(64'h8000_0000);

    logic            busy_reg;
    logic            done_reg;
    logic            neg_reg;
    logic            zero_den_reg;
    logic            num_neg_reg;
    logic            num_zero_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [QW-1:0]   sh_reg;
    logic [32:0]     rem_reg;
    logic [32:0]     dmag_reg;
    logic signed [31:0] quot_reg;
    logic            err_reg;

    logic [32:0] num_mag;
    logic [32:0] trial;
    logic        take;
    logic [QW-1:0] neg_q;

    always_comb
    begin
        num_mag = num[32] ? 33'(-num) : 33'(num);
        trial   = {rem_reg[31:0], sh_reg[QW-1]};
        take    = trial >= dmag_reg;
        neg_q   = -sh_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                done_reg     <= 1'b0;
                busy_reg     <= 1'b1;
                neg_reg      <= num[32] ^ den[31];
                zero_den_reg <= (den == 32'sd0);
                num_neg_reg  <= num[32];
                num_zero_reg <= (num == 33'sd0);
                dmag_reg     <= den[31] ? 33'(-{den[31], den}) : {1'b0, den};
                sh_reg       <= {num_mag[31:0], {FRAC_BITS{1'b0}}};
                rem_reg      <= '0;
                cnt_reg      <= CNTW'(QW);
            end
            else if (busy_reg)
            begin
                if (zero_den_reg)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    err_reg  <= 1'b1;
                    if (num_zero_reg)
                    begin
                        quot_reg <= 32'sd0;
                    end
                    else if (num_neg_reg)
                    begin
                        quot_reg <= FIX_MIN;
                    end
                    else
                    begin
                        quot_reg <= FIX_MAX;
                    end
                end
                else if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    if (!neg_reg)
                    begin
                        err_reg  <= sh_reg > POS_LIM;
                        quot_reg <= (sh_reg > POS_LIM) ? FIX_MAX : sh_reg[31:0];
                    end
                    else
                    begin
                        err_reg  <= sh_reg > NEG_LIM;
                        quot_reg <= (sh_reg > NEG_LIM) ? FIX_MIN : neg_q[31:0];
                    end
                end
                else
                begin
                    done_reg <= 1'b0;
                    rem_reg  <= take ? (trial - dmag_reg) : trial;
                    sh_reg   <= {sh_reg[QW-2:0], take};
                    cnt_reg  <= cnt_reg - CNTW'(1);
                end
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign err  = err_reg;

endmodule

FILE: rtl/tridiagonal_sweep_solver_top.sv
// Tridiagonal (Thomas) solver top: per-row forward sweep, then back-substitution and output.
// Each row before the last runs two passes of the serial divider, first for Q and then for P;
// the last row takes one divide, then each earlier row is back-substituted and each word is sent out.
// One row at a time: input stalls from acceptance until that row's sweep, or the solve, is done.
// Reset: row count, error flag and control clear; rows_in_use returns to 4; stores are not cleared.
// Uses tds_pkg, tds_store, tds_mul, tds_div.
`timescale 1ns / 1ps
module tridiagonal_sweep_solver_top
    import tds_pkg::*;
#(
    parameter int MAX_ROWS  = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        row_valid,
    output logic        row_stall,
    input  row_word_t   row,
    output logic        sol_valid,
    input  logic        sol_stall,
    output sol_word_t   sol
);

    localparam int IW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = IW + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_MUL1, S_MUL2, S_DIVQ, S_DIVP,
        S_BRD, S_BMUL, S_BADD, S_ERD, S_ELD
    } state_t;

    state_t state_reg;
    logic [4:0]    rows_reg;
    logic [IW-1:0] row_count_reg;
    logic          err_reg;
    logic [IW-1:0] i_reg;
    logic [IW-1:0] k_reg;
    logic          first_reg;
    logic          last_reg;
    logic signed [31:0] a_reg, b_reg, c_reg, d_reg;
    logic signed [31:0] den_reg;
    logic signed [31:0] x_reg;
    logic          sol_valid_reg;
    sol_word_t     sol_reg;

    logic [CW-1:0] n_eff;
    logic          is_last;
    logic          row_acc;
    logic          cfg_wr;

    logic          st_wr_p, st_wr_q, st_rd;
    logic [IW-1:0] st_waddr, st_raddr;
    logic [31:0]   st_wq_data;
    logic [31:0]   rd_p, rd_q;
    logic signed [31:0] pp, qq;

    logic          mul_start;
    logic signed [31:0] mul_x, mul_y, mres;
    logic          mres_ovf;

    logic          div_start, div_done, div_err;
    logic signed [32:0] div_num;
    logic signed [31:0] div_quot;

    logic signed [32:0] den_sum, num_diff, bk_sum;
    logic          out_free;

    assign pready = 1'b1;
    assign prdata = {27'd0, rows_reg};
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_ROWS_IN_USE);

    assign row_stall = (state_reg != S_IDLE);
    assign row_acc   = row_valid && !row_stall;
    assign sol_valid = sol_valid_reg;
    assign sol       = sol_reg;
    assign out_free  = !sol_valid_reg || !sol_stall;

    always_comb
    begin
        if (rows_reg < ROWS_MIN)
        begin
            n_eff = CW'(2);
        end
        else if (32'(rows_reg) > 32'(MAX_ROWS))
        begin
            n_eff = CW'(MAX_ROWS);
        end
        else
        begin
            n_eff = CW'(rows_reg);
        end
        is_last = ({1'b0, row_count_reg} + CW'(1)) >= n_eff;
    end

    assign pp = first_reg ? 32'sd0 : $signed(rd_p);
    assign qq = first_reg ? 32'sd0 : $signed(rd_q);

    always_comb
    begin
        den_sum  = {b_reg[31], b_reg} + {mres[31], mres};
        num_diff = {d_reg[31], d_reg} - {mres[31], mres};
        bk_sum   = {mres[31], mres} + {rd_q[31], rd_q};
    end

    // Strobes for the store, multiplier and divider.
    always_comb
    begin
        st_wr_p    = 1'b0;
        st_wr_q    = 1'b0;
        st_waddr   = i_reg;
        st_wq_data = div_quot;
        st_rd      = 1'b0;
        st_raddr   = k_reg;
        mul_start  = 1'b0;
        mul_x      = a_reg;
        mul_y      = pp;
        div_start  = 1'b0;
        div_num    = {num_diff[32], sat33(num_diff)};
        unique case (state_reg)
            S_IDLE:
            begin
                st_rd    = row_acc;
                st_raddr = row_count_reg - IW'(1);
            end
            S_RD:
            begin
                mul_start = 1'b1;
            end
            S_MUL1:
            begin
                mul_start = 1'b1;
                mul_y     = qq;
            end
            S_MUL2:
            begin
                div_start = 1'b1;
            end
            S_DIVQ:
            begin
                st_wr_q   = div_done;
                div_start = div_done && !last_reg;
                div_num   = -{c_reg[31], c_reg};
            end
            S_DIVP:
            begin
                st_wr_p = div_done;
            end
            S_BRD:
            begin
                st_rd = 1'b1;
            end
            S_BMUL:
            begin
                mul_start = 1'b1;
                mul_x     = rd_p;
                mul_y     = x_reg;
            end
            S_BADD:
            begin
                st_wr_q    = 1'b1;
                st_waddr   = k_reg;
                st_wq_data = sat33(bk_sum);
            end
            S_ERD:
            begin
                st_rd = 1'b1;
            end
            S_ELD:
            begin
            end
            default:
            begin
            end
        endcase
    end

    tds_store #(
        .DEPTH (MAX_ROWS),
        .AW    (IW)
    ) u_store (
        .clk       (clk),
        .wr_p      (st_wr_p),
        .wr_q      (st_wr_q),
        .wr_addr   (st_waddr),
        .wr_p_data (div_quot),
        .wr_q_data (st_wq_data),
        .rd_en     (st_rd),
        .rd_addr   (st_raddr),
        .rd_p_data (rd_p),
        .rd_q_data (rd_q)
    );

    tds_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk   (clk),
        .start (mul_start),
        .x     (mul_x),
        .y     (mul_y),
        .res   (mres),
        .ovf   (mres_ovf)
    );

    tds_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (den_reg),
        .done  (div_done),
        .quot  (div_quot),
        .err   (div_err)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rows_reg      <= ROWS_RESET;
            row_count_reg <= '0;
            err_reg       <= 1'b0;
            sol_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                rows_reg <= pwdata[4:0];
            end
            // in S_ELD the output register is reloaded instead
            if (sol_valid_reg && !sol_stall && (state_reg != S_ELD))
            begin
                sol_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (row_acc)
                    begin
                        a_reg     <= (row_count_reg == '0) ? 32'sd0 : row.sub_coef;
                        b_reg     <= row.diag_coef;
                        c_reg     <= row.super_coef;
                        d_reg     <= row.rhs_value;
                        i_reg     <= row_count_reg;
                        first_reg <= (row_count_reg == '0);
                        last_reg  <= is_last;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_MUL1;
                end
                S_MUL1:
                begin
                    den_reg   <= sat33(den_sum);
                    err_reg   <= err_reg | mres_ovf | ovf33(den_sum);
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    err_reg   <= err_reg | mres_ovf | ovf33(num_diff);
                    state_reg <= S_DIVQ;
                end
                S_DIVQ:
                begin
                    if (div_done)
                    begin
                        err_reg <= err_reg | div_err;
                        x_reg   <= div_quot;
                        if (!last_reg)
                        begin
                            state_reg <= S_DIVP;
                        end
                        else if (i_reg == '0)
                        begin
                            k_reg     <= i_reg;
                            state_reg <= S_ERD;
                        end
                        else
                        begin
                            k_reg     <= i_reg - IW'(1);
                            state_reg <= S_BRD;
                        end
                    end
                end
                S_DIVP:
                begin
                    if (div_done)
                    begin
                        err_reg       <= err_reg | div_err;
                        row_count_reg <= i_reg + IW'(1);
                        state_reg     <= S_IDLE;
                    end
                end
                S_BRD:
                begin
                    state_reg <= S_BMUL;
                end
                S_BMUL:
                begin
                    state_reg <= S_BADD;
                end
                S_BADD:
                begin
                    x_reg   <= sat33(bk_sum);
                    err_reg <= err_reg | mres_ovf | ovf33(bk_sum);
                    if (k_reg == '0)
                    begin
                        k_reg     <= i_reg;
                        state_reg <= S_ERD;
                    end
                    else
                    begin
                        k_reg     <= k_reg - IW'(1);
                        state_reg <= S_BRD;
                    end
                end
                S_ERD:
                begin
                    state_reg <= S_ELD;
                end
                S_ELD:
                begin
                    if (out_free)
                    begin
                        sol_valid_reg     <= 1'b1;
                        sol_reg.x_value   <= rd_q;
                        sol_reg.x_index   <= 4'(k_reg);
                        sol_reg.last_flag <= (k_reg == '0);
                        sol_reg.singular  <= err_reg;
                        if (k_reg == '0)
                        begin
                            row_count_reg <= '0;
                            err_reg       <= 1'b0;
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            k_reg     <= k_reg - IW'(1);
                            state_reg <= S_ERD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for tridiagonal_sweep_solver_top: rows in, solution words checked.
// Holds its own fixed-point Thomas sweep predictor; depends on tds_pkg and the solver RTL.
`timescale 1ns / 1ps
module testbench;
    import tds_pkg::*;

    localparam int  NROWS       = 16;
    localparam int  FBITS       = 16;
    localparam int  RANDOM_ROWS = 250;
    localparam int  CYCLE_LIMIT = 600000;
    localparam int  SETTLE      = 400;
    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        row_valid = 1'b0;
    logic        row_stall;
    row_word_t   row = '0;
    logic        sol_valid;
    logic        sol_stall = 1'b0;
    sol_word_t   sol;

    row_word_t   pending_rows[$];
    sol_word_t   expected_sols[$];
    int          mismatches = 0;
    int          cycles = 0;
    bit          quiet = 1'b0;
    bit          long_hold_req = 1'b0;
    bit          long_hold_done = 1'b0;
    bit          row_held = 1'b0;
    int          hold_cnt = 0;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          rows_queued = 0;

    // predictor state
    longint      p_store[NROWS];
    longint      q_store[NROWS];
    int          rows_seen = 0;
    bit          err_flag = 1'b0;
    logic [4:0]  rows_cfg = ROWS_RESET;

    tridiagonal_sweep_solver_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .row_valid(row_valid), .row_stall(row_stall), .row(row),
        .sol_valid(sol_valid), .sol_stall(sol_stall), .sol(sol)
    );

    always #4 clk = ~clk;

    function automatic longint clip(input longint v);
        if (v > SMAX)
        begin
            err_flag = 1'b1;
            return SMAX;
        end
        if (v < SMIN)
        begin
            err_flag = 1'b1;
            return SMIN;
        end
        return v;
    endfunction

    function automatic longint fix_mul(input longint x, input longint y);
        longint prod;
        prod = x * y + (64'sd1 <<< (FBITS - 1));
        return clip(prod >>> FBITS);
    endfunction

    function automatic longint fix_div(input longint num, input longint den);
        if (den == 0)
        begin
            err_flag = 1'b1;
            if (num > 0) return SMAX;
            if (num < 0) return SMIN;
            return 0;
        end
        return clip((num * (64'sd1 <<< FBITS)) / den);
    endfunction

    function automatic int rows_effective(input logic [4:0] v);
        if (v < 2) return 2;
        if (v > NROWS) return NROWS;
        return int'(v);
    endfunction

    // forward sweep for one row; back-substitution when the system completes
    task automatic sweep_row(input row_word_t w);
        longint    a, b, c, d, pp, qq, den;
        longint    xs[NROWS];
        int        n, i;
        sol_word_t s;
        n = rows_effective(rows_cfg);
        i = (rows_seen >= NROWS) ? NROWS - 1 : rows_seen;
        a = (i == 0) ? 0 : longint'(w.sub_coef);
        b = longint'(w.diag_coef);
        c = longint'(w.super_coef);
        d = longint'(w.rhs_value);
        pp = (i == 0) ? 0 : p_store[i - 1];
        qq = (i == 0) ? 0 : q_store[i - 1];
        den = clip(b + fix_mul(a, pp));
        q_store[i] = fix_div(clip(d - fix_mul(a, qq)), den);
        if (i + 1 < n)
        begin
            p_store[i] = fix_div(-c, den);
            rows_seen = i + 1;
        end
        else
        begin
            xs[i] = q_store[i];
            for (int k = i - 1; k >= 0; k--)
            begin
                xs[k] = clip(fix_mul(p_store[k], xs[k + 1]) + q_store[k]);
            end
            for (int k = i; k >= 0; k--)
            begin
                s.x_value   = xs[k][31:0];
                s.x_index   = 4'(k);
                s.last_flag = (k == 0);
                s.singular  = err_flag;
                expected_sols.push_back(s);
            end
            rows_seen = 0;
            err_flag = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // row word offered but not taken at this edge
    always @(posedge clk)
    begin
        row_held <= row_valid && row_stall;
    end

    // predictor and checker sample at the rising edge
    always @(posedge clk)
    begin
        sol_word_t want;
        if (rst_n && row_valid && !row_stall)
        begin
            sweep_row(row);
        end
        if (rst_n && sol_valid && !sol_stall)
        begin
            if (expected_sols.size() == 0)
            begin
                $error("unexpected solution word: x_value %h x_index %0d", sol.x_value,
                       sol.x_index);
                mismatches++;
            end
            else
            begin
                want = expected_sols.pop_front();
                if (sol.x_value !== want.x_value)
                begin
                    $error("x_value: expected %h actual %h", want.x_value, sol.x_value);
                    mismatches++;
                end
                if (sol.x_index !== want.x_index)
                begin
                    $error("x_index: expected %0d actual %0d", want.x_index, sol.x_index);
                    mismatches++;
                end
                if (sol.last_flag !== want.last_flag)
                begin
                    $error("last_flag: expected %b actual %b", want.last_flag, sol.last_flag);
                    mismatches++;
                end
                if (sol.singular !== want.singular)
                begin
                    $error("singular: expected %b actual %b", want.singular, sol.singular);
                    mismatches++;
                end
            end
        end
    end

    // row driver: holds a stalled word, otherwise pops the next or idles in bursts
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            row_valid <= 1'b0;
        end
        else if (row_valid && row_held)
        begin
            row_valid <= 1'b1;
        end
        else if (send_gap > 0)
        begin
            send_gap <= send_gap - 1;
            row_valid <= 1'b0;
        end
        else if (pending_rows.size() != 0)
        begin
            if (!quiet && $urandom_range(0, 9) == 0)
            begin
                send_gap <= $urandom_range(0, 15);
                row_valid <= 1'b0;
            end
            else
            begin
                row <= pending_rows.pop_front();
                row_valid <= 1'b1;
            end
        end
        else
        begin
            row_valid <= 1'b0;
        end
    end

    // solution receiver: random stall bursts plus one long hold-off
    always @(negedge clk)
    begin
        if (long_hold_req && !long_hold_done && sol_valid)
        begin
            long_hold_done <= 1'b1;
            hold_cnt <= 1500;
            sol_stall <= 1'b1;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            sol_stall <= 1'b1;
        end
        else if (recv_gap > 0)
        begin
            recv_gap <= recv_gap - 1;
            sol_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            recv_gap <= $urandom_range(0, 15);
            sol_stall <= 1'b1;
        end
        else
        begin
            sol_stall <= 1'b0;
        end
    end

    task automatic write_rows_in_use(input logic [4:0] v);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_ROWS_IN_USE;
        pwdata <= {27'd0, v};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        rows_cfg = v;
    endtask

    task automatic wait_idle();
        while (pending_rows.size() != 0 || expected_sols.size() != 0 || row_valid)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic add_row(input logic [31:0] a, input logic [31:0] b,
                           input logic [31:0] c, input logic [31:0] d);
        row_word_t w;
        w.sub_coef = a;
        w.diag_coef = b;
        w.super_coef = c;
        w.rhs_value = d;
        pending_rows.push_back(w);
        rows_queued++;
    endtask

    // diagonally dominant system with random content, or raw noise
    task automatic add_system(input bit noisy);
        int n;
        logic [31:0] dg;
        n = rows_effective(rows_cfg);
        for (int k = 0; k < n; k++)
        begin
            if (noisy || $urandom_range(0, 39) == 0)
            begin
                add_row($urandom, $urandom, $urandom, $urandom);
            end
            else
            begin
                dg = $urandom_range(3 << FBITS, 6 << FBITS);
                if ($urandom_range(0, 1)) dg = -dg;
                add_row($urandom_range(0, 2 << FBITS) - (1 << FBITS), dg,
                        $urandom_range(0, 2 << FBITS) - (1 << FBITS),
                        $urandom_range(0, 32 << FBITS) - (16 << FBITS));
            end
        end
    endtask

    initial
    begin
        logic [4:0] cfg;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset size of 4, extremes, zero pivots, saturation
        add_row(32'h8000_0000, 32'h0001_0000, 32'h0000_8000, 32'h0002_0000);
        add_row(32'h0000_4000, 32'h0003_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        add_row(32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        add_row(32'hFFFF_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        wait_idle();
        write_rows_in_use(5'd2);
        add_row(32'h0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);     // zero pivot first row
        add_row(32'h0001_0000, 32'h0002_0000, 32'h0, 32'h8000_0000);
        add_row(32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000);     // negative numerator
        add_row(32'h0, 32'h0, 32'h0, 32'h0);                      // zero over zero
        add_row(32'h0, 32'h0000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_row(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8000_0001);
        wait_idle();
        write_rows_in_use(5'd0);                                  // below range acts as 2
        add_row(32'h0, 32'h0002_0000, 32'h0001_0000, 32'h0004_0000);
        add_row(32'h0001_0000, 32'h0003_0000, 32'h0, 32'h0005_0000);
        wait_idle();
        write_rows_in_use(5'd31);                                 // above range acts as 16
        add_system(1'b0);
        wait_idle();

        // random systems across sizes; one long hold-off
        while (rows_queued < RANDOM_ROWS)
        begin
            case ($urandom_range(0, 5))
                0: cfg = 5'd16;
                1: cfg = 5'(($urandom_range(0, 1)) ? $urandom_range(0, 1)
                                                   : 17 + $urandom_range(0, 14));
                default: cfg = 5'($urandom_range(2, 6));
            endcase
            write_rows_in_use(cfg);
            if (rows_queued > 120 && !long_hold_req)
            begin
                long_hold_req = 1'b1;
                write_rows_in_use(5'd16);
            end
            if (rows_queued > RANDOM_ROWS - 20) quiet = 1'b1;
            for (int s = 0; s < 3; s++)
            begin
                add_system($urandom_range(0, 4) == 0);
            end
            wait_idle();
        end

        if (mismatches == 0 && expected_sols.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: tridiagonal_sweep_solver_top.f
rtl/tds_pkg.sv
rtl/tds_store.sv
rtl/tds_mul.sv
rtl/tds_div.sv
rtl/tridiagonal_sweep_solver_top.sv
tb/testbench.sv
